// ===== design/ffha_pkg.sv =====
// ffha_pkg: shared codes, field widths and stream layout of the heap allocator
// used by first_fit_heap_allocator and its port checker; no dependencies
package ffha_pkg;

    localparam int MODE_W = 3;
    localparam int SIZE_W = 17;
    localparam int ADDR_W = 32;
    localparam int STAT_W = 2;
    localparam int SG_W   = 14;    // request size in granules, any 17-bit request

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 88;

    // result tdata layout
    localparam int OUT_LF_LSB = 32;
    localparam int OUT_TF_LSB = 49;
    localparam int OUT_TU_LSB = 66;

    localparam logic [SIZE_W-1:0] SAT17      = 17'h1FFFF;
    localparam logic [ADDR_W-1:0] ALIGN_MASK = ~32'hF;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC_FRONT = 3'd0,
        MODE_ALLOC_BACK  = 3'd1,
        MODE_FREE        = 3'd2,
        MODE_RESIZE      = 3'd3,
        MODE_QUERY       = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_NO_SHRINK = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_BYTES = 1'b1
    } cfg_idx_t;

endpackage

// ===== design/ffha_hdr_ram.sv =====
// ffha_hdr_ram: simple dual-port memory, one write and one registered read a cycle
// holds the block header words of the heap allocator; no dependencies
module ffha_hdr_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4096
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: top level of the header-chained heap allocator
// depends on ffha_pkg and ffha_hdr_ram
//
// Usage: one request transaction on the s_ side (s_tuser = mode, s_tdata = size
// and block address) gives exactly one result transaction on the m_ side
// (m_tuser = status, m_tdata = address and query totals). Requests are served
// one at a time. Block headers live in two memories (size/flags and predecessor
// link), each read once per cycle through a registered read port.
// Alloc from start walks the block chain at one header per cycle, as does the
// totals query. Alloc from end walks forward to the last block and back.
// Free reads the block, its successor and its predecessor and then writes the
// merged headers; resize works in place or, when the block has to move, does a
// front walk plus a free. A request rejected on decode goes straight to its result.
// Reset and every configuration write start a clearing pass over the header memories,
// during which s_tready stays low; configuration writes are taken at any time and
// restart the pass.
// A finished result sits in the output register until m_tready; the next
// request is accepted meanwhile, and a further result waits for the register.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_GRANULES = 4096,
    parameter int HEADER_BYTES  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // req_size[16:0], block_addr[48:17]
    input  logic [MODE_W-1:0]    s_tuser,   // mode[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // result_addr[31:0], largest_free[48:32],
                                            // total_free[65:49], total_used[82:66]
    output logic [STAT_W-1:0]    m_tuser,   // status[1:0]
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int GW = (HEAP_GRANULES > 1) ? $clog2(HEAP_GRANULES) : 1;
    localparam int CW = $clog2(HEAP_GRANULES + 1);
    localparam int AW = ((CW > SG_W) ? CW : SG_W) + 2;
    localparam int HG = (HEADER_BYTES + 15) / 16;
    localparam logic [ADDR_W-1:0] HDR_B  = ADDR_W'(HG * 16);
    localparam logic [AW-1:0]     HG_A   = AW'(HG);
    localparam logic [CW-1:0]     G_LAST = CW'(HEAP_GRANULES - 1);
    localparam int RST_G = (HEAP_GRANULES < 4096) ? HEAP_GRANULES : 4096;

    typedef struct packed {
        logic          valid;
        logic          free;
        logic [GW-1:0] size;
    } hdr_t;

    typedef struct packed {
        logic          hen;
        logic [GW-1:0] ha;
        hdr_t          hd;
        logic          pen;
        logic [GW-1:0] pa;
        logic [GW-1:0] pd;
    } cmw_t;

    localparam int HW = $bits(hdr_t);

    typedef enum logic [14:0] {
        S_CLR  = 15'b000000000000001,
        S_HDR0 = 15'b000000000000010,
        S_IDLE = 15'b000000000000100,
        S_AF   = 15'b000000000001000,
        S_ABF  = 15'b000000000010000,
        S_ABB  = 15'b000000000100000,
        S_LK   = 15'b000000001000000,
        S_RSN  = 15'b000000010000000,
        S_FR0  = 15'b000000100000000,
        S_FRG  = 15'b000001000000000,
        S_FRN  = 15'b000010000000000,
        S_FRP  = 15'b000100000000000,
        S_QW   = 15'b001000000000000,
        S_CM   = 15'b010000000000000,
        S_FIN  = 15'b100000000000000
    } state_t;

    function automatic hdr_t mk_hdr(input logic v, input logic f, input logic [AW-1:0] sz);
        hdr_t h;
        h.valid = v;
        h.free  = f;
        h.size  = GW'(sz);
        return h;
    endfunction

    function automatic cmw_t mk_cm(input logic hen, input logic [AW-1:0] ha, input hdr_t hd,
                                   input logic pen, input logic [AW-1:0] pa,
                                   input logic [AW-1:0] pd);
        cmw_t c;
        c.hen = hen;
        c.ha  = GW'(ha);
        c.hd  = hd;
        c.pen = pen;
        c.pa  = GW'(pa);
        c.pd  = GW'(pd);
        return c;
    endfunction

    function automatic logic [SIZE_W-1:0] sat_bytes(input logic [CW-1:0] v);
        logic [ADDR_W-1:0] w;
        w = ADDR_W'(v) << 4;
        return (w > ADDR_W'(SAT17)) ? SAT17 : w[SIZE_W-1:0];
    endfunction

    // control state
    state_t            state_reg, state_next;
    logic [CW-1:0]     clr_reg, clr_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [CW-1:0]     heapg_reg, heapg_next;
    logic              first_reg, first_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        cmk_reg, cmk_next;
    logic              mvr_reg, mvr_next;

    // request payload and scratch
    mode_t             op_reg, op_next;
    logic [SG_W-1:0]   sg_reg, sg_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [GW-1:0]     blk_reg, blk_next;
    logic [GW-1:0]     cur_reg, cur_next;
    hdr_t              hg_reg, hg_next;
    logic [GW-1:0]     pg_reg, pg_next;
    logic [AW-1:0]     nn_reg, nn_next;
    logic              nok_reg, nok_next;
    hdr_t              hn_reg, hn_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    status_t           st_reg, st_next;
    logic [GW-1:0]     mx_reg, mx_next;
    logic [CW-1:0]     sf_reg, sf_next;
    logic [CW-1:0]     su_reg, su_next;
    cmw_t [2:0]        cm_reg, cm_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [STAT_W-1:0]    out_user_reg, out_user_next;

    // memory ports
    logic          h_we, p_we;
    logic [GW-1:0] h_wa, p_wa, rd_addr;
    hdr_t          h_wd, rd_h;
    logic [GW-1:0] p_wd, rd_p;
    logic [HW-1:0] rd_h_raw;

    ffha_hdr_ram #(.DATA_W(HW), .DEPTH(HEAP_GRANULES)) u_hdr_ram (
        .aclk (aclk),
        .we   (h_we),
        .waddr(h_wa),
        .wdata(h_wd),
        .raddr(rd_addr),
        .rdata(rd_h_raw)
    );

    ffha_hdr_ram #(.DATA_W(GW), .DEPTH(HEAP_GRANULES)) u_prev_ram (
        .aclk (aclk),
        .we   (p_we),
        .waddr(p_wa),
        .wdata(p_wd),
        .raddr(rd_addr),
        .rdata(rd_p)
    );

    assign rd_h = hdr_t'(rd_h_raw);

    // header just read at cur_reg
    logic [AW-1:0] heap_a, cur_a, size_a, sg_a, n_cur, n_fit;
    logic          n_in, fit, split;
    assign heap_a = AW'(heapg_reg);
    assign cur_a  = AW'(cur_reg);
    assign size_a = AW'(rd_h.size);
    assign sg_a   = AW'(sg_reg);
    assign n_cur  = cur_a + HG_A + size_a;
    assign n_fit  = cur_a + HG_A + sg_a;
    assign n_in   = n_cur < heap_a;
    assign fit    = rd_h.free && (size_a >= sg_a);
    assign split  = (sg_a + HG_A) < size_a;

    // incoming request decode
    logic [SIZE_W:0]   in_sum;
    logic [SG_W-1:0]   in_sg;
    logic [ADDR_W-1:0] in_addr, in_off;
    logic              off_ok;
    mode_t             in_mode;
    assign in_sum  = (SIZE_W+1)'(s_tdata[SIZE_W-1:0]) + (SIZE_W+1)'(15);
    assign in_sg   = in_sum[SIZE_W:4];
    assign in_addr = s_tdata[SIZE_W +: ADDR_W];
    assign in_off  = in_addr - base_reg - HDR_B;
    assign off_ok  = first_reg && (in_off[3:0] == 4'd0)
                     && (in_off[ADDR_W-1:4] < (ADDR_W-4)'(heapg_reg));
    assign in_mode = mode_t'(s_tuser);

    // resize and free helpers from saved headers
    logic [AW-1:0] g_a, gsz_a, hsz_a, psz_a, diff_a, t_gr, t_sh, fsz_a, m_fr;
    logic          nfree, merge_p;
    assign g_a     = AW'(blk_reg);
    assign gsz_a   = AW'(hg_reg.size);
    assign hsz_a   = AW'(hn_reg.size);
    assign psz_a   = AW'(rd_h.size);
    assign nfree   = nok_reg && hn_reg.free;
    assign diff_a  = sg_a - gsz_a;
    assign t_gr    = nn_reg + diff_a;
    assign t_sh    = g_a + HG_A + sg_a;
    assign fsz_a   = gsz_a + (nfree ? (hsz_a + HG_A) : AW'(0));
    assign m_fr    = g_a + HG_A + fsz_a;
    assign merge_p = (blk_reg != '0) && (pg_reg < blk_reg) && rd_h.free;

    // resize read of the successor (latched into hn_reg in S_RSN)
    hdr_t rsn_h;
    assign rsn_h = rd_h;

    cmw_t cm_cur;
    assign cm_cur = cm_reg[cmk_reg];

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        base_next      = base_reg;
        heapg_next     = heapg_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmk_next       = cmk_reg;
        mvr_next       = mvr_reg;
        op_next        = op_reg;
        sg_next        = sg_reg;
        addr_next      = addr_reg;
        blk_next       = blk_reg;
        cur_next       = cur_reg;
        hg_next        = hg_reg;
        pg_next        = pg_reg;
        nn_next        = nn_reg;
        nok_next       = nok_reg;
        hn_next        = hn_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        mx_next        = mx_reg;
        sf_next        = sf_reg;
        su_next        = su_reg;
        cm_next        = cm_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        rd_addr        = cur_reg;
        h_we           = 1'b0;
        h_wa           = cm_cur.ha;
        h_wd           = cm_cur.hd;
        p_we           = 1'b0;
        p_wa           = cm_cur.pa;
        p_wd           = cm_cur.pd;

        unique case (state_reg)
            S_CLR: begin
                h_we     = 1'b1;
                h_wa     = clr_reg[GW-1:0];
                h_wd     = '0;
                p_we     = 1'b1;
                p_wa     = clr_reg[GW-1:0];
                p_wd     = '0;
                clr_next = clr_reg + CW'(1);
                if (clr_reg == G_LAST) begin
                    state_next = S_HDR0;
                end
            end
            S_HDR0: begin
                h_we       = first_reg;
                h_wa       = '0;
                h_wd       = mk_hdr(1'b1, 1'b1, heap_a - HG_A);
                p_we       = first_reg;
                p_wa       = '0;
                p_wd       = '0;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    sg_next   = in_sg;
                    addr_next = in_addr;
                    res_next  = '0;
                    st_next   = ST_DONE;
                    mvr_next  = 1'b0;
                    mx_next   = '0;
                    sf_next   = '0;
                    su_next   = '0;
                    cur_next  = '0;
                    rd_addr   = '0;
                    priority if (in_mode == MODE_ALLOC_FRONT ||
                                 (in_mode == MODE_RESIZE && in_addr == '0)) begin
                        op_next    = MODE_ALLOC_FRONT;
                        st_next    = first_reg ? ST_DONE : ST_NO_ROOM;
                        state_next = first_reg ? S_AF : S_FIN;
                    end else if (in_mode == MODE_ALLOC_BACK) begin
                        op_next    = MODE_ALLOC_BACK;
                        st_next    = first_reg ? ST_DONE : ST_NO_ROOM;
                        state_next = first_reg ? S_ABF : S_FIN;
                    end else if (in_mode == MODE_FREE || in_mode == MODE_RESIZE) begin
                        op_next    = (in_mode == MODE_FREE || in_sg == '0) ? MODE_FREE
                                                                           : MODE_RESIZE;
                        blk_next   = in_off[4 +: GW];
                        cur_next   = in_off[4 +: GW];
                        rd_addr    = in_off[4 +: GW];
                        st_next    = off_ok ? ST_DONE : ST_IGNORED;
                        state_next = off_ok ? S_LK : S_FIN;
                    end else if (in_mode == MODE_QUERY) begin
                        op_next    = MODE_QUERY;
                        state_next = first_reg ? S_QW : S_FIN;
                    end else begin
                        op_next    = MODE_FREE;
                        st_next    = ST_IGNORED;
                        state_next = S_FIN;
                    end
                end
            end
            S_AF: begin
                if (fit) begin
                    res_next = base_reg + HDR_B + (ADDR_W'(cur_reg) << 4);
                    if (split) begin
                        cm_next[0] = mk_cm(1'b1, n_fit,
                                           mk_hdr(1'b1, 1'b1, size_a - sg_a - HG_A),
                                           1'b1, n_fit, cur_a);
                        cm_next[1] = mk_cm(1'b1, cur_a, mk_hdr(1'b1, 1'b0, sg_a),
                                           n_in, n_cur, n_fit);
                    end else begin
                        cm_next[0] = mk_cm(1'b1, cur_a, mk_hdr(1'b1, 1'b0, size_a),
                                           1'b0, '0, '0);
                        cm_next[1] = '0;
                    end
                    cm_next[2] = '0;
                    cmk_next   = '0;
                    state_next = S_CM;
                end else if (n_in) begin
                    cur_next = GW'(n_cur);
                    rd_addr  = GW'(n_cur);
                end else begin
                    // no room: a resize that wanted to move leaves its block alone
                    st_next    = ST_NO_ROOM;
                    res_next   = '0;
                    mvr_next   = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_ABF: begin
                if (n_in) begin
                    cur_next = GW'(n_cur);
                    rd_addr  = GW'(n_cur);
                end else begin
                    rd_addr    = cur_reg;
                    state_next = S_ABB;
                end
            end
            S_ABB: begin
                if (fit) begin
                    if (split) begin
                        // grant is cut from the top of the free block
                        cm_next[0] = mk_cm(1'b1, cur_a + size_a - sg_a,
                                           mk_hdr(1'b1, 1'b0, sg_a),
                                           1'b1, cur_a + size_a - sg_a, cur_a);
                        cm_next[1] = mk_cm(1'b1, cur_a,
                                           mk_hdr(1'b1, 1'b1, size_a - sg_a - HG_A),
                                           n_in, n_cur, cur_a + size_a - sg_a);
                        res_next   = base_reg + HDR_B
                                     + (ADDR_W'(GW'(cur_a + size_a - sg_a)) << 4);
                    end else begin
                        cm_next[0] = mk_cm(1'b1, cur_a, mk_hdr(1'b1, 1'b0, size_a),
                                           1'b0, '0, '0);
                        cm_next[1] = '0;
                        res_next   = base_reg + HDR_B + (ADDR_W'(cur_reg) << 4);
                    end
                    cm_next[2] = '0;
                    cmk_next   = '0;
                    state_next = S_CM;
                end else if (cur_reg == '0 || rd_p >= cur_reg) begin
                    st_next    = ST_NO_ROOM;
                    state_next = S_FIN;
                end else begin
                    cur_next = rd_p;
                    rd_addr  = rd_p;
                end
            end
            S_LK: begin
                hg_next  = rd_h;
                nn_next  = n_cur;
                nok_next = n_in;
                if (!rd_h.valid || rd_h.free) begin
                    st_next    = ST_IGNORED;
                    state_next = S_FIN;
                end else if (op_reg == MODE_FREE) begin
                    state_next = S_FR0;
                end else if (sg_a == size_a) begin
                    res_next   = addr_reg;
                    state_next = S_FIN;
                end else begin
                    rd_addr    = n_in ? GW'(n_cur) : cur_reg;
                    state_next = S_RSN;
                end
            end
            S_RSN: begin
                hn_next = rsn_h;
                if (sg_a > gsz_a) begin
                    if (nok_reg && rsn_h.free && AW'(rsn_h.size) >= diff_a) begin
                        // grow in place into the free successor
                        cm_next[0] = mk_cm(1'b1, t_gr,
                                           mk_hdr(1'b1, 1'b1, AW'(rsn_h.size) - diff_a),
                                           1'b1, t_gr, g_a);
                        cm_next[1] = mk_cm(1'b1, nn_reg, '0,
                                           (nn_reg + HG_A + AW'(rsn_h.size)) < heap_a,
                                           nn_reg + HG_A + AW'(rsn_h.size), t_gr);
                        cm_next[2] = mk_cm(1'b1, g_a, mk_hdr(1'b1, 1'b0, sg_a),
                                           1'b0, '0, '0);
                        cmk_next   = '0;
                        res_next   = addr_reg;
                        state_next = S_CM;
                    end else begin
                        mvr_next   = 1'b1;
                        cur_next   = '0;
                        rd_addr    = '0;
                        state_next = S_AF;
                    end
                end else if (nok_reg && rsn_h.free) begin
                    // shrink and hand the spare granules to the free successor
                    cm_next[0] = mk_cm(1'b1, nn_reg, '0, 1'b0, '0, '0);
                    cm_next[1] = mk_cm(1'b1, t_sh,
                                       mk_hdr(1'b1, 1'b1, AW'(rsn_h.size) + gsz_a - sg_a),
                                       1'b1, t_sh, g_a);
                    cm_next[2] = mk_cm(1'b1, g_a, mk_hdr(1'b1, 1'b0, sg_a),
                                       (nn_reg + HG_A + AW'(rsn_h.size)) < heap_a,
                                       nn_reg + HG_A + AW'(rsn_h.size), t_sh);
                    cmk_next   = '0;
                    res_next   = addr_reg;
                    state_next = S_CM;
                end else if ((sg_a + HG_A) < gsz_a) begin
                    cm_next[0] = mk_cm(1'b1, t_sh,
                                       mk_hdr(1'b1, 1'b1, gsz_a - sg_a - HG_A),
                                       1'b1, t_sh, g_a);
                    cm_next[1] = mk_cm(1'b1, g_a, mk_hdr(1'b1, 1'b0, sg_a),
                                       nok_reg, nn_reg, t_sh);
                    cm_next[2] = '0;
                    cmk_next   = '0;
                    res_next   = addr_reg;
                    state_next = S_CM;
                end else begin
                    st_next    = ST_NO_SHRINK;
                    state_next = S_FIN;
                end
            end
            S_FR0: begin
                cur_next   = blk_reg;
                rd_addr    = blk_reg;
                state_next = S_FRG;
            end
            S_FRG: begin
                hg_next    = rd_h;
                pg_next    = rd_p;
                nn_next    = n_cur;
                nok_next   = n_in;
                rd_addr    = n_in ? GW'(n_cur) : cur_reg;
                state_next = S_FRN;
            end
            S_FRN: begin
                hn_next    = rd_h;
                rd_addr    = pg_reg;
                state_next = S_FRP;
            end
            S_FRP: begin
                cm_next[0] = mk_cm(nfree, nn_reg, '0, 1'b0, '0, '0);
                cm_next[1] = mk_cm(1'b1, g_a,
                                   merge_p ? hdr_t'('0) : mk_hdr(1'b1, 1'b1, fsz_a),
                                   (nfree || merge_p) && (m_fr < heap_a), m_fr,
                                   merge_p ? AW'(pg_reg) : g_a);
                cm_next[2] = mk_cm(merge_p, AW'(pg_reg),
                                   mk_hdr(1'b1, 1'b1, psz_a + fsz_a + HG_A),
                                   1'b0, '0, '0);
                cmk_next   = '0;
                state_next = S_CM;
            end
            S_QW: begin
                if (rd_h.free) begin
                    sf_next = sf_reg + CW'(rd_h.size);
                    if (rd_h.size > mx_reg) begin
                        mx_next = rd_h.size;
                    end
                end else begin
                    su_next = su_reg + CW'(rd_h.size);
                end
                if (n_in) begin
                    cur_next = GW'(n_cur);
                    rd_addr  = GW'(n_cur);
                end else begin
                    state_next = S_FIN;
                end
            end
            S_CM: begin
                h_we     = cm_cur.hen;
                p_we     = cm_cur.pen;
                cmk_next = cmk_reg + 2'd1;
                if (cmk_reg == 2'd2) begin
                    mvr_next   = 1'b0;
                    state_next = mvr_reg ? S_FR0 : S_FIN;
                end
            end
            S_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[ADDR_W-1:0] = res_reg;
                    if (op_reg == MODE_QUERY) begin
                        out_data_next[OUT_LF_LSB +: SIZE_W] = sat_bytes(CW'(mx_reg));
                        out_data_next[OUT_TF_LSB +: SIZE_W] = sat_bytes(sf_reg);
                        out_data_next[OUT_TU_LSB +: SIZE_W] = sat_bytes(su_reg);
                    end
                    out_user_next = st_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
                clr_next   = '0;
            end
        endcase

        // a configuration write restarts the clearing pass, which rebuilds the heap as one free block if it has room
        if (cfg_wr_en) begin
            if (cfg_idx_t'(cfg_index) == CFG_HEAP_BASE) begin
                base_next = cfg_data & ALIGN_MASK;
            end else begin
                if (ADDR_W'(cfg_data[SIZE_W-1:4]) > ADDR_W'(HEAP_GRANULES)) begin
                    heapg_next = CW'(HEAP_GRANULES);
                end else begin
                    heapg_next = CW'(cfg_data[SIZE_W-1:4]);
                end
                first_next = AW'(heapg_next) > HG_A;
            end
            state_next = S_CLR;
            clr_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            base_reg      <= '0;
            heapg_reg     <= CW'(RST_G);
            first_reg     <= (RST_G > HG);
            out_valid_reg <= 1'b0;
            cmk_reg       <= '0;
            mvr_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            base_reg      <= base_next;
            heapg_reg     <= heapg_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            cmk_reg       <= cmk_next;
            mvr_reg       <= mvr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sg_reg       <= sg_next;
        addr_reg     <= addr_next;
        blk_reg      <= blk_next;
        cur_reg      <= cur_next;
        hg_reg       <= hg_next;
        pg_reg       <= pg_next;
        nn_reg       <= nn_next;
        nok_reg      <= nok_next;
        hn_reg       <= hn_next;
        res_reg      <= res_next;
        st_reg       <= st_next;
        mx_reg       <= mx_next;
        sf_reg       <= sf_next;
        su_reg       <= su_next;
        cm_reg       <= cm_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== design/ffha_chk.sv =====
// ffha_chk: port-level checks for first_fit_heap_allocator, bound to the top level
// depends on ffha_pkg
module ffha_chk
    import ffha_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]    m_tuser
);

    logic [SIZE_W-1:0] lf, tf, tu;
    assign lf = m_tdata[OUT_LF_LSB +: SIZE_W];
    assign tf = m_tdata[OUT_TF_LSB +: SIZE_W];
    assign tu = m_tdata[OUT_TU_LSB +: SIZE_W];

    // reset starts the clearing pass with nothing pending on either side
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("transaction offered right after reset");

    // every failing status comes without an address
    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DONE |-> m_tdata[ADDR_W-1:0] == '0)
        else $error("failed request returned an address");

    // totals appear only on successful queries
    a_totals_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (lf != '0 || tf != '0 || tu != '0)
        |-> m_tuser == ST_DONE && m_tdata[ADDR_W-1:0] == '0)
        else $error("totals on a non-query result");

    a_largest_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> lf <= tf)
        else $error("largest free block exceeds total free");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (.*);
